// ===== hdl/vhist_pkg.sv =====
`timescale 1ns / 1ps

package vhist_pkg;

    localparam int VALUE_W     = 10;
    localparam int CLIENT_W    = 2;
    localparam int COUNT_W     = 14;
    localparam int RUN_W       = 15;
    localparam int DISTINCT_W  = 11;
    localparam int MIN_W       = 11;
    localparam int NUM_VALUES  = 1024;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 48;
    localparam int CLEAR_W     = VALUE_W + 1;

    localparam logic [COUNT_W-1:0]    COUNT_MAX        = 14'd16383;
    localparam logic [RUN_W-1:0]      MAX_RUN          = 15'd16384;
    localparam logic [RUN_W-1:0]      RUN_LENGTH_RESET = 15'd10000;
    localparam logic [MIN_W-1:0]      MIN_RESET        = 11'd1024;

endpackage

// ===== hdl/vhist_ram.sv =====
`timescale 1ns / 1ps

module vhist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/value_histogram_with_extremes_top.sv =====
`timescale 1ns / 1ps

// Value histogram with running extremes.
// Requests arrive on the s_ channel: a 10-bit value and a 2-bit client tag.
// Each request is answered on the m_ channel with the client tag and the
// number of times the value occurred earlier in the run. The request that
// completes the run (cfg run length, written through cfg_wr_en) raises
// m_tlast and carries the distinct count, the largest and the smallest value.
// Requests after that are taken and dropped until the next reset.
// A request is registered in the read stage with its bin read, and its result
// in the output register that drives m_tvalid. The block takes one request per
// cycle while the output is not stalled: a request reads its histogram bin in
// the cycle it is accepted and writes it back as it leaves the read stage, and
// a write-back to the same bin is forwarded to the following request.
// After aresetn is released, a clearing pass zeroes the 1024 histogram bins;
// s_tready stays low during it.
// When the receiver holds m_tready low, the result waits in the output
// register, one further request waits in the read stage, and then s_tready
// drops until the output is taken.
module value_histogram_with_extremes_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // value[9:0], client[11:10], zero[15:12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // reply_client[1:0], prior_count[15:2],
                                    // distinct_values[26:16], largest_value[36:27],
                                    // smallest_value[47:37]
    output logic        m_tlast     // run_done
);

    localparam int AW = vhist_pkg::VALUE_W;
    localparam int CW = vhist_pkg::COUNT_W;

    logic [vhist_pkg::RUN_W-1:0]      run_len_reg;
    logic [vhist_pkg::CLEAR_W-1:0]    clr_cnt_reg;
    logic                             clearing;

    logic                             b_valid_reg;
    logic [AW-1:0]                    b_addr_reg;
    logic [vhist_pkg::CLIENT_W-1:0]   b_client_reg;
    logic                             b_adv;

    logic                             fwd_valid_reg;
    logic [AW-1:0]                    fwd_addr_reg;
    logic [CW-1:0]                    fwd_data_reg;

    logic [vhist_pkg::RUN_W-1:0]      items_reg;
    logic [vhist_pkg::DISTINCT_W-1:0] distinct_reg;
    logic [vhist_pkg::MIN_W-1:0]      min_reg;
    logic [AW-1:0]                    max_reg;
    logic                             finished_reg;

    logic                             out_valid_reg;
    logic [47:0]                      out_data_reg;
    logic                             out_last_reg;

    logic                             accept;
    logic [CW-1:0]                    rd_data;
    logic [CW-1:0]                    prior;
    logic [CW-1:0]                    bumped;
    logic                             do_count;
    logic [vhist_pkg::RUN_W-1:0]      eff_len;
    logic [vhist_pkg::RUN_W-1:0]      items_next;
    logic [vhist_pkg::DISTINCT_W-1:0] distinct_next;
    logic [vhist_pkg::MIN_W-1:0]      min_next;
    logic [AW-1:0]                    max_next;
    logic                             done;
    logic                             ram_wr_en;
    logic [AW-1:0]                    ram_wr_addr;
    logic [CW-1:0]                    ram_wr_data;

    assign clearing = ~clr_cnt_reg[vhist_pkg::CLEAR_W-1];
    assign b_adv    = b_valid_reg & (finished_reg | ~out_valid_reg | m_tready);
    assign s_tready = ~clearing & (~b_valid_reg | b_adv);
    assign accept   = s_tvalid & s_tready;
    assign do_count = b_adv & ~finished_reg;

    always_comb begin
        if (fwd_valid_reg && fwd_addr_reg == b_addr_reg) begin
            prior = fwd_data_reg;
        end else begin
            prior = rd_data;
        end
        bumped = (prior < vhist_pkg::COUNT_MAX) ? prior + CW'(1) : prior;

        if (run_len_reg == '0) begin
            eff_len = vhist_pkg::RUN_W'(1);
        end else if (run_len_reg > vhist_pkg::MAX_RUN) begin
            eff_len = vhist_pkg::MAX_RUN;
        end else begin
            eff_len = run_len_reg;
        end

        items_next    = items_reg + vhist_pkg::RUN_W'(1);
        done          = items_next >= eff_len;
        distinct_next = (prior == '0) ? distinct_reg + vhist_pkg::DISTINCT_W'(1)
                                      : distinct_reg;
        min_next      = ({1'b0, b_addr_reg} < min_reg) ? {1'b0, b_addr_reg} : min_reg;
        max_next      = (b_addr_reg > max_reg) ? b_addr_reg : max_reg;

        if (clearing) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg[AW-1:0];
            ram_wr_data = '0;
        end else begin
            ram_wr_en   = do_count;
            ram_wr_addr = b_addr_reg;
            ram_wr_data = bumped;
        end
    end

    vhist_ram #(
        .WIDTH (CW),
        .DEPTH (vhist_pkg::NUM_VALUES)
    ) u_vhist_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (s_tdata[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg   <= vhist_pkg::RUN_LENGTH_RESET;
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            items_reg     <= '0;
            distinct_reg  <= '0;
            min_reg       <= vhist_pkg::MIN_RESET;
            max_reg       <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                run_len_reg <= cfg_wr_data;
            end
            if (clearing) begin
                clr_cnt_reg <= clr_cnt_reg + vhist_pkg::CLEAR_W'(1);
            end

            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end

            if (b_adv) begin
                fwd_valid_reg <= do_count;
            end

            if (do_count) begin
                items_reg    <= items_next;
                distinct_reg <= distinct_next;
                min_reg      <= min_next;
                max_reg      <= max_next;
                finished_reg <= done;
            end

            if (do_count) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_addr_reg   <= s_tdata[AW-1:0];
            b_client_reg <= s_tdata[AW+vhist_pkg::CLIENT_W-1:AW];
        end
        if (do_count) begin
            fwd_addr_reg <= b_addr_reg;
            fwd_data_reg <= bumped;
            out_last_reg <= done;
            out_data_reg <= {done ? min_next : vhist_pkg::MIN_W'(0),
                             done ? max_next : AW'(0),
                             done ? distinct_next : vhist_pkg::DISTINCT_W'(0),
                             prior,
                             b_client_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("request accepted during the clearing pass");

    a_finished_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |=> finished_reg)
        else $error("run end flag dropped without reset");

    a_summary_only_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[47:16] == 32'd0))
        else $error("summary fields set on a result before the end of the run");

    a_distinct_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        distinct_reg <= 11'd1024)
        else $error("distinct count exceeds the number of bins");
`endif

endmodule
